[rtl/lgs_pkg.sv]
// ----------------------------------------------------------------------------
// lgs_pkg
// shared types and constants for the life generation step core
// ----------------------------------------------------------------------------
`default_nettype none

package lgs_pkg;

	localparam int ROW_W  = 64;   // bits in one grid row
	localparam int IDX_W  = 6;    // bit index within a row
	localparam int CNT_W  = 7;    // row and column counts, 0..64
	localparam int NUM_W  = 6;    // row number on the output
	localparam int ADDR_W = 4;    // apb byte address
	localparam int DATA_W = 32;   // apb data

	// register indexes, paddr[3:2]
	localparam logic [1:0] REG_ROWS = 2'd0;
	localparam logic [1:0] REG_COLS = 2'd1;
	localparam logic [1:0] REG_HOLD = 2'd2;

	typedef logic [ROW_W-1:0] row_t;

	// settings that the row evaluator needs for one generation
	typedef struct packed {
		logic [CNT_W-1:0] cols;   // effective column count, 1..MAX_COLS
		logic             hold;   // emit cells unchanged
	} eval_cfg_t;

endpackage

`default_nettype wire

[rtl/lgs_ram.sv]
// ----------------------------------------------------------------------------
// lgs_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/lgs_lane.sv]
// ----------------------------------------------------------------------------
// lgs_lane
// life rule for one cell from its 3x3 neighborhood
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_lane (
	input  wire logic [2:0] above,   // left, center, right of the row above
	input  wire logic [2:0] mid,     // mid[1] is the cell itself
	input  wire logic [2:0] below,
	input  wire logic       hold,
	output logic            next
);

	logic [3:0] sum;
	logic       self;

	assign self = mid[1];

	// eight neighbors, duplicates on tiny grids counted as they come
	assign sum = 4'(above[0]) + 4'(above[1]) + 4'(above[2])
	           + 4'(mid[0])   + 4'(mid[2])
	           + 4'(below[0]) + 4'(below[1]) + 4'(below[2]);

	always_comb begin
		if (hold) begin
			next = self;
		end else if (self) begin
			next = (sum == 4'd2) || (sum == 4'd3);
		end else begin
			next = (sum == 4'd3);
		end
	end

endmodule

`default_nettype wire

[rtl/lgs_row_eval.sv]
// ----------------------------------------------------------------------------
// lgs_row_eval
// one lane per column, toroidal column wrap, merges lane bits into a masked row
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_row_eval #(
	parameter int MAX_COLS = 64
) (
	input  wire lgs_pkg::row_t      prev_row,
	input  wire lgs_pkg::row_t      cur_row,
	input  wire lgs_pkg::row_t      nxt_row,
	input  wire lgs_pkg::eval_cfg_t cfg,
	output lgs_pkg::row_t           next_row
);

	import lgs_pkg::*;

	logic [CNT_W-1:0] cols_m1;
	logic [2:0]       wrap_l;   // column cols-1 of prev, cur, next

	assign cols_m1 = cfg.cols - CNT_W'(1);
	assign wrap_l  = {nxt_row[cols_m1[IDX_W-1:0]], cur_row[cols_m1[IDX_W-1:0]],
	                  prev_row[cols_m1[IDX_W-1:0]]};

	for (genvar c = 0; c < ROW_W; c++) begin : g_col
		if (c < MAX_COLS) begin : g_lane
			logic [2:0] left;    // per row: prev, cur, next
			logic [2:0] center;
			logic [2:0] right;
			logic       lane_next;

			assign center = {nxt_row[c], cur_row[c], prev_row[c]};

			if (c == 0) begin : g_left_wrap
				assign left = wrap_l;
			end else begin : g_left
				assign left = {nxt_row[c-1], cur_row[c-1], prev_row[c-1]};
			end

			if (c == ROW_W-1) begin : g_right_wrap
				assign right = {nxt_row[0], cur_row[0], prev_row[0]};
			end else begin : g_right
				assign right = (cfg.cols == CNT_W'(c+1))
				             ? {nxt_row[0], cur_row[0], prev_row[0]}
				             : {nxt_row[c+1], cur_row[c+1], prev_row[c+1]};
			end

			lgs_lane u_lane (
				.above ({right[0], center[0], left[0]}),
				.mid   ({right[1], center[1], left[1]}),
				.below ({right[2], center[2], left[2]}),
				.hold  (cfg.hold),
				.next  (lane_next)
			);

			assign next_row[c] = lane_next && (CNT_W'(c) < cfg.cols);
		end else begin : g_off
			assign next_row[c] = 1'b0;
		end
	end

endmodule

`default_nettype wire

[rtl/life_generation_step_core.sv]
// ----------------------------------------------------------------------------
// life_generation_step_core
// one generation of toroidal conway life over a grid streamed in as row beats
// ----------------------------------------------------------------------------
// A generation of R rows (rows_in_use, clamped to 1..MAX_ROWS) comes in as R
// input beats, one grid row each, at one beat per cycle; each row is written
// to a frame ram. The beat that completes the frame switches the core to
// emission: it then holds in_stall high and emits R output beats, one per
// cycle while the sink does not stall, each carrying the next generation of
// one row with its row number and a last_row flag on the final one. The output
// is registered: the first output beat goes valid when the output register
// loads, after the closing input beat has switched the core to emission. The
// single read port of the frame ram, read one row ahead into a three row
// window, sets the emission pace. Every column has its own rule lane, so a
// full row is evaluated at once, combinationally. Rows and columns
// wrap at the configured counts; output bits at and above the column
// count are zero. The row count, column count and hold in force on the beat
// that completes a frame govern its emission. Registers sit on an apb port at
// byte addresses 0, 4 and 8 and should only be written while no frame is in
// flight. The frame ram needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module life_generation_step_core #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,

	// apb configuration port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [lgs_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [lgs_pkg::DATA_W-1:0]  pwdata,
	output logic      [lgs_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,

	// input rows
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire lgs_pkg::row_t               row_cells,

	// output rows
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output lgs_pkg::row_t                    next_row_cells,
	output logic      [lgs_pkg::NUM_W-1:0]   row_number,
	output logic                             last_row
);

	import lgs_pkg::*;

	localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

	// configuration registers
	logic [CNT_W-1:0] rows_in_use_q;
	logic [CNT_W-1:0] cols_in_use_q;
	logic             hold_q;

	// control
	state_t           state_q;
	logic [CNT_W-1:0] rows_received_q;
	logic [CNT_W-1:0] row_q;        // row being evaluated
	logic [CNT_W-1:0] nidx_q;       // row index that sits in the next slot
	logic [CNT_W-1:0] frame_rows_q; // row count of the frame being emitted
	eval_cfg_t        frame_cfg_q;
	logic             out_valid_q;

	// row payload
	row_t             prev_q;
	row_t             cur_q;
	row_t             row0_q;       // row 0 of the frame
	row_t             rowlast_q;    // last row of the frame
	row_t             out_row_q;
	logic [NUM_W-1:0] out_num_q;
	logic             out_last_q;

	// combinational
	logic             cfg_wr;
	logic [CNT_W-1:0] eff_rows;
	logic [CNT_W-1:0] eff_cols;
	logic             in_fire;
	logic [CNT_W-1:0] wr_idx;
	logic [CNT_W-1:0] wr_cnt;
	logic             frame_done;
	logic [CNT_W-1:0] nidx_init;
	logic [CNT_W-1:0] nidx_inc;
	logic [CNT_W-1:0] nidx_next;
	logic             advance;
	logic             ram_re;
	logic [CNT_W-1:0] ram_ridx;
	row_t             ram_rdata;
	row_t             nxt_row;
	row_t             eval_row;

	// ------------------------------------------------------------------------
	// apb registers, write on the access phase
	// ------------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_in_use_q <= CNT_W'(64);
			cols_in_use_q <= CNT_W'(64);
			hold_q        <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_ROWS: rows_in_use_q <= pwdata[CNT_W-1:0];
				REG_COLS: cols_in_use_q <= pwdata[CNT_W-1:0];
				REG_HOLD: hold_q        <= pwdata[0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ROWS: prdata = DATA_W'(rows_in_use_q);
			REG_COLS: prdata = DATA_W'(cols_in_use_q);
			REG_HOLD: prdata = DATA_W'(hold_q);
			default:  prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------------
	// effective counts: zero reads as one, overlarge reads as the maximum
	// ------------------------------------------------------------------------
	always_comb begin
		priority if (rows_in_use_q == '0) begin
			eff_rows = CNT_W'(1);
		end else if (rows_in_use_q > CNT_W'(MAX_ROWS)) begin
			eff_rows = CNT_W'(MAX_ROWS);
		end else begin
			eff_rows = rows_in_use_q;
		end

		priority if (cols_in_use_q == '0) begin
			eff_cols = CNT_W'(1);
		end else if (cols_in_use_q > CNT_W'(MAX_COLS)) begin
			eff_cols = CNT_W'(MAX_COLS);
		end else begin
			eff_cols = cols_in_use_q;
		end
	end

	// ------------------------------------------------------------------------
	// load side
	// ------------------------------------------------------------------------
	assign in_stall = (state_q != ST_LOAD);
	assign in_fire  = in_valid && (state_q == ST_LOAD);

	// a row count lowered mid frame to no more than the rows already received restarts the frame at row 0
	assign wr_idx     = (rows_received_q >= eff_rows) ? '0 : rows_received_q;
	assign wr_cnt     = wr_idx + CNT_W'(1);
	assign frame_done = in_fire && (wr_cnt == eff_rows);

	// first row after row 0 in wrap order
	assign nidx_init = (eff_rows == CNT_W'(1)) ? '0 : CNT_W'(1);

	// ------------------------------------------------------------------------
	// emission side: window of prev, cur and next rows
	// ------------------------------------------------------------------------
	assign advance   = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign nidx_inc  = nidx_q + CNT_W'(1);
	assign nidx_next = (nidx_inc == frame_rows_q) ? '0 : nidx_inc;

	// fetch one row ahead; read data holds while the window waits
	assign ram_re   = frame_done || advance;
	assign ram_ridx = frame_done ? nidx_init : nidx_next;

	// row 0 and the last row live in registers, the rest come from the ram
	always_comb begin
		priority if (nidx_q == '0) begin
			nxt_row = row0_q;
		end else if (nidx_q == frame_rows_q - CNT_W'(1)) begin
			nxt_row = rowlast_q;
		end else begin
			nxt_row = ram_rdata;
		end
	end

	lgs_ram #(
		.WIDTH (ROW_W),
		.DEPTH (MAX_ROWS)
	) u_frame_ram (
		.clk   (clk),
		.we    (in_fire),
		.waddr (wr_idx[AW-1:0]),
		.wdata (row_cells),
		.re    (ram_re),
		.raddr (ram_ridx[AW-1:0]),
		.rdata (ram_rdata)
	);

	lgs_row_eval #(
		.MAX_COLS (MAX_COLS)
	) u_row_eval (
		.prev_row (prev_q),
		.cur_row  (cur_q),
		.nxt_row  (nxt_row),
		.cfg      (frame_cfg_q),
		.next_row (eval_row)
	);

	// ------------------------------------------------------------------------
	// state and control
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_LOAD;
			rows_received_q <= '0;
			row_q           <= '0;
			nidx_q          <= '0;
			frame_rows_q    <= CNT_W'(1);
			frame_cfg_q     <= '{cols: CNT_W'(1), hold: 1'b0};
			out_valid_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_fire) begin
						rows_received_q <= frame_done ? '0 : wr_cnt;
					end
					if (frame_done) begin
						state_q      <= ST_EMIT;
						row_q        <= '0;
						nidx_q       <= nidx_init;
						frame_rows_q <= eff_rows;
						frame_cfg_q  <= '{cols: eff_cols, hold: hold_q};
					end
				end
				ST_EMIT: begin
					if (advance) begin
						row_q  <= row_q + CNT_W'(1);
						nidx_q <= nidx_next;
						if (row_q == frame_rows_q - CNT_W'(1)) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase

			// output register: loads on advance, empties when taken
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// row payload
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_fire && (wr_idx == '0)) begin
			row0_q <= row_cells;
		end
		if (frame_done) begin
			rowlast_q <= row_cells;
			prev_q    <= row_cells;
			cur_q     <= (wr_idx == '0) ? row_cells : row0_q;
		end else if (advance) begin
			prev_q <= cur_q;
			cur_q  <= nxt_row;
		end
		if (advance) begin
			out_row_q  <= eval_row;
			out_num_q  <= row_q[NUM_W-1:0];
			out_last_q <= (row_q == frame_rows_q - CNT_W'(1));
		end
	end

	assign out_valid      = out_valid_q;
	assign next_row_cells = out_row_q;
	assign row_number     = out_num_q;
	assign last_row       = out_last_q;

endmodule

`default_nettype wire

[rtl/lgs_checker.sv]
// ----------------------------------------------------------------------------
// lgs_checker
// port level checks on the output beats of the life generation step core
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_stall,
	input  wire logic                       out_valid,
	input  wire logic                       out_stall,
	input  wire lgs_pkg::row_t              next_row_cells,
	input  wire logic [lgs_pkg::NUM_W-1:0]  row_number,
	input  wire logic                       last_row
);

	import lgs_pkg::*;

	logic out_fire;

	assign out_fire = out_valid && !out_stall;

	// rows of a generation follow back to back in order
	a_row_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !last_row |=>
			out_valid && (row_number == NUM_W'($past(row_number) + NUM_W'(1))))
		else $error("row beat missing or out of order");

	// after the last row comes nothing or row 0 of the next generation
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && last_row |=> !out_valid || (row_number == '0))
		else $error("beat right after last row is not row 0");

	// no new rows taken while a generation is still going out
	a_load_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_row |-> in_stall)
		else $error("input open during emission");

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=>
			out_valid && $stable(next_row_cells) && $stable(row_number)
			&& $stable(last_row))
		else $error("stalled output beat changed");

endmodule

bind life_generation_step_core lgs_checker u_lgs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.next_row_cells (next_row_cells),
	.row_number     (row_number),
	.last_row       (last_row)
);

`default_nettype wire
